// File: rtl/lsoz_pkg.sv
// Shared types and constants for the laser scan obstacle zone block.
`timescale 1ns / 1ps
`default_nettype none

package lsoz_pkg;

  // Range field width and fixed point layout
  localparam int RANGE_BITS   = 16;
  localparam int FRAC         = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int ZW           = 32;                // binary angle width in the rotator
  localparam int XW           = RANGE_BITS + 7;    // rotator x/y: Q.4 plus sign and gain growth
  localparam int PW           = 23;                // point after gain and sensor shift, Q.4
  localparam int D2W          = 2 * PW;            // squared distance, Q.8
  localparam int TW           = 22;                // thresholds, Q.4, unsigned
  localparam int MW           = 32;                // shared multiplier operand width

  // CORDIC gain correction, 0.60725 in Q30
  localparam logic signed [MW-1:0] GAIN_Q30 = 32'sd652032874;
  localparam int GAIN_SHIFT = 30;

  localparam logic [ZW-1:0] QUARTER_TURN = 32'h4000_0000;

  // atan(2^-i) in 2^-32 turn
  localparam logic signed [ZW-1:0] ARC_TABLE [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;
  localparam logic [CFG_AW-1:0] REG_ANGLE_STEP      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ANGLE_START     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SENSOR_X_SHIFT  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SIDE_HALF_WIDTH = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MARGIN_DISTANCE = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BODY_RADIUS     = 3'd5;

  // Register reset values
  localparam logic [22:0]        ANGLE_STEP_RST      = 23'd0;
  localparam logic signed [23:0] ANGLE_START_RST     = -24'sd6328339;
  localparam logic signed [15:0] SENSOR_X_SHIFT_RST  = 16'sd130;
  localparam logic [15:0]        SIDE_HALF_WIDTH_RST = 16'd80;
  localparam logic [15:0]        MARGIN_DISTANCE_RST = 16'd100;
  localparam logic [15:0]        BODY_RADIUS_RST     = 16'd120;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_mm;
    logic                  range_ok;
    logic                  scan_end;
  } in_item_t;

  typedef struct packed {
    logic near_left;
    logic near_front;
    logic near_right;
    logic approaching_front;
  } out_item_t;

  // Per-sample control handed from the front end to the zone sequencer
  typedef struct packed {
    logic range_ok;
    logic scan_end;
  } item_ctl_t;

  // Zone geometry registers
  typedef struct packed {
    logic signed [15:0] sensor_x_shift;
    logic [15:0]        side_half_width;
    logic [15:0]        margin_distance;
    logic [15:0]        body_radius;
  } zone_cfg_t;

  // One vector moving along the rotator cells
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  typedef enum logic [3:0] {
    ZS_IDLE,
    ZS_ROT,
    ZS_GX,
    ZS_GY,
    ZS_SX,
    ZS_SY,
    ZS_TB,
    ZS_TH,
    ZS_T1,
    ZS_T2,
    ZS_UPD
  } zone_state_t;

endpackage

`default_nettype wire

// File: rtl/lsoz_cell.sv
// One CORDIC micro-rotation cell with a fixed shift.
`timescale 1ns / 1ps
`default_nettype none

module lsoz_cell
  import lsoz_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic vld_in,
  input  wire rot_t vec_in,
  output logic      vld_out,
  output rot_t      vec_out
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  rot_t                 vec_nxt;
  logic                 vld_r;
  rot_t                 vec_r;

  assign dx = vec_in.y >>> IDX;
  assign dy = vec_in.x >>> IDX;

  always_comb begin
    if (!vec_in.z[ZW-1]) begin
      vec_nxt.x = vec_in.x - dx;
      vec_nxt.y = vec_in.y + dy;
      vec_nxt.z = vec_in.z - ARC_TABLE[IDX];
    end else begin
      vec_nxt.x = vec_in.x + dx;
      vec_nxt.y = vec_in.y - dy;
      vec_nxt.z = vec_in.z + ARC_TABLE[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  // data moves every cycle, valid tags it
  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign vld_out = vld_r;
  assign vec_out = vec_r;

endmodule

`default_nettype wire

// File: rtl/lsoz_rotator.sv
// Quadrant fold and row of CORDIC cells turning a range into x and y.
`timescale 1ns / 1ps
`default_nettype none

module lsoz_rotator
  import lsoz_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [RANGE_BITS-1:0] range_mm,
  input  wire logic [ZW-1:0]         bin_angle,
  output logic                       vld_out,
  output rot_t                       vec_out
);

  logic [ZW-1:0]        ang_sum;
  logic                 fold;
  logic signed [XW-1:0] r_q4;
  rot_t                 entry;

  logic                 vld_c [CORDIC_STEPS+1];
  rot_t                 vec_c [CORDIC_STEPS+1];

  // angles in the left half plane start from (-r, 0), turned by half a turn
  assign ang_sum = bin_angle + QUARTER_TURN;
  assign fold    = ang_sum[ZW-1];
  assign r_q4    = $signed(XW'({range_mm, 4'b0000}));

  always_comb begin
    entry.x = fold ? -r_q4 : r_q4;
    entry.y = '0;
    entry.z = $signed({bin_angle[ZW-1] ^ fold, bin_angle[ZW-2:0]});
  end

  assign vld_c[0] = start;
  assign vec_c[0] = entry;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    lsoz_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (vld_c[i]),
      .vec_in (vec_c[i]),
      .vld_out(vld_c[i+1]),
      .vec_out(vec_c[i+1])
    );
  end

  assign vld_out = vld_c[CORDIC_STEPS];
  assign vec_out = vec_c[CORDIC_STEPS];

endmodule

`default_nettype wire

// File: rtl/lsoz_zone.sv
// Gain removal, squared distances, zone tests, sticky flags and result register.
`timescale 1ns / 1ps
`default_nettype none

module lsoz_zone
  import lsoz_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire item_ctl_t ctl,
  input  wire zone_cfg_t cfg,
  input  wire logic      rot_vld,
  input  wire rot_t      rot,
  output logic           busy,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  zone_state_t          state_r, state_nxt;
  item_ctl_t            ctl_r;
  logic signed [XW-1:0] xc_r, yc_r;
  logic signed [PW-1:0] xs_r, ys_r;
  logic [D2W-1:0]       d2_r;
  logic                 keep_r, half_r, one_r;
  logic [TW-1:0]        tb_r, th_r, t1_r, t2_r;
  logic signed [MW-1:0] ma, mb;
  logic signed [2*MW-1:0] p_r;
  logic [D2W-1:0]       p_sq;
  logic signed [PW-1:0] p_gain;
  logic signed [PW-1:0] x_shift_q4;
  logic signed [PW-1:0] side_q4;
  logic                 in_left, in_right, hit, two;
  logic                 done, emit;
  out_item_t            seen_r, seen_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  assign p_sq       = p_r[D2W-1:0];
  assign p_gain     = $signed(p_r[GAIN_SHIFT +: PW]);
  assign x_shift_q4 = PW'($signed({cfg.sensor_x_shift, 4'b0000}));
  assign side_q4    = $signed(PW'({cfg.side_half_width, 4'b0000}));

  // thresholds follow the registers, settled long before they are used
  always_ff @(posedge clk) begin
    tb_r <= TW'({cfg.body_radius, 4'b0000});
    th_r <= TW'({cfg.body_radius, 4'b0000}) + TW'({cfg.margin_distance, 3'b000});
    t1_r <= TW'({cfg.body_radius, 4'b0000}) + TW'({cfg.margin_distance, 4'b0000});
    t2_r <= TW'({cfg.body_radius, 4'b0000}) + TW'({cfg.margin_distance, 5'b00000});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ZS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: one product per state through the shared multiplier
  always_comb begin
    state_nxt = state_r;
    ma        = $signed(MW'(t2_r));
    mb        = $signed(MW'(t2_r));
    done      = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ZS_IDLE: begin
        if (start) begin
          state_nxt = ctl.range_ok ? ZS_ROT : ZS_UPD;
        end
      end
      ZS_ROT: begin
        if (rot_vld) begin
          state_nxt = ZS_GX;
        end
      end
      ZS_GX: begin
        ma        = MW'(xc_r);
        mb        = GAIN_Q30;
        state_nxt = ZS_GY;
      end
      ZS_GY: begin
        ma        = MW'(yc_r);
        mb        = GAIN_Q30;
        state_nxt = ZS_SX;
      end
      ZS_SX: begin
        ma        = MW'(xs_r);
        mb        = MW'(xs_r);
        state_nxt = ZS_SY;
      end
      ZS_SY: begin
        ma        = MW'(ys_r);
        mb        = MW'(ys_r);
        state_nxt = ZS_TB;
      end
      ZS_TB: begin
        ma        = $signed(MW'(tb_r));
        mb        = $signed(MW'(tb_r));
        state_nxt = ZS_TH;
      end
      ZS_TH: begin
        ma        = $signed(MW'(th_r));
        mb        = $signed(MW'(th_r));
        state_nxt = ZS_T1;
      end
      ZS_T1: begin
        ma        = $signed(MW'(t1_r));
        mb        = $signed(MW'(t1_r));
        state_nxt = ZS_T2;
      end
      ZS_T2: begin
        state_nxt = ZS_UPD;
      end
      ZS_UPD: begin
        // product holds t2 squared here
        if (!ctl_r.scan_end) begin
          done      = 1'b1;
          state_nxt = ZS_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          done      = 1'b1;
          emit      = 1'b1;
          state_nxt = ZS_IDLE;
        end
      end
      default: begin
        state_nxt = ZS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    if (state_r == ZS_IDLE && start) begin
      ctl_r <= ctl;
    end
    if (state_r == ZS_ROT && rot_vld) begin
      xc_r <= rot.x;
      yc_r <= rot.y;
    end
    if (state_r == ZS_GY) begin
      xs_r <= p_gain + x_shift_q4;
    end
    if (state_r == ZS_SX) begin
      ys_r <= p_gain;
    end
    if (state_r == ZS_SY) begin
      d2_r <= p_sq;
    end
    if (state_r == ZS_TB) begin
      d2_r <= d2_r + p_sq;
    end
    if (state_r == ZS_TH) begin
      keep_r <= d2_r >= p_sq;
    end
    if (state_r == ZS_T1) begin
      half_r <= d2_r < p_sq;
    end
    if (state_r == ZS_T2) begin
      one_r <= d2_r < p_sq;
    end
  end

  assign in_left  = ys_r > side_q4;
  assign in_right = ys_r < -side_q4;
  assign hit      = ctl_r.range_ok && keep_r;
  assign two      = d2_r < p_sq;

  always_comb begin
    seen_nxt.near_left         = seen_r.near_left  | (hit && in_left && half_r);
    seen_nxt.near_right        = seen_r.near_right | (hit && !in_left && in_right && half_r);
    seen_nxt.near_front        = seen_r.near_front | (hit && !in_left && !in_right && one_r);
    seen_nxt.approaching_front = seen_r.approaching_front |
                                 (hit && !in_left && !in_right && two);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may load in the same cycle the old one leaves
      if (done && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        if (emit) begin
          seen_r <= '0;
        end else begin
          seen_r <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= seen_nxt;
    end
  end

  assign busy      = (state_r != ZS_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/laser_scan_obstacle_zones.sv
// Top level: laser range samples in, obstacle zone flags out once per scan.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Beat
// -------  ---  -----------------  -------------------------------------------
// in_      in   in_valid/in_stall  in_item_t: range_mm, range_ok, scan_end
// out_     out  out_valid/out_stall out_item_t: near_left/front/right,
//                                   approaching_front (only on scan_end)
// cfg_     in   cfg_valid/cfg_ready cfg_index selects register, cfg_data value
//
// A valid sample passes the row of 16 CORDIC cells, then 8 products through the
// one shared 32x32 multiplier (gain on x and y, two squares, four threshold
// squares) and one flag update; the next sample is taken once the sequencer is
// back in idle. An invalid sample goes from its accept straight to the update.
// One sample is in flight at a time; in_stall is high while it is. Reset
// (synchronous, rst_n low) loads the register defaults, clears the zone flags
// and sets the beam angle to angle_start. A scan-end result waits in the
// output register; the next sample is taken meanwhile and only another scan
// end holds behind an output stall.

module laser_scan_obstacle_zones
  import lsoz_pkg::*;
#(
  parameter int ANGLE_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_AW-1:0]    cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data
);

  localparam int ASH = ZW - ANGLE_BITS;

  logic [22:0]           angle_step_r;
  logic signed [23:0]    angle_start_r;
  zone_cfg_t             zcfg_r;
  logic [ANGLE_BITS-1:0] beam_angle_r;
  logic [ZW-1:0]         bin_angle;
  logic                  in_acc;
  logic                  busy;
  item_ctl_t             ctl;
  logic                  rot_vld;
  rot_t                  rot_vec;

  // configuration must be written only between samples; the block does not enforce it, so no hold-off
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_step_r           <= ANGLE_STEP_RST;
      angle_start_r          <= ANGLE_START_RST;
      zcfg_r.sensor_x_shift  <= SENSOR_X_SHIFT_RST;
      zcfg_r.side_half_width <= SIDE_HALF_WIDTH_RST;
      zcfg_r.margin_distance <= MARGIN_DISTANCE_RST;
      zcfg_r.body_radius     <= BODY_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANGLE_STEP:      angle_step_r           <= cfg_data[22:0];
        REG_ANGLE_START:     angle_start_r          <= $signed(cfg_data[23:0]);
        REG_SENSOR_X_SHIFT:  zcfg_r.sensor_x_shift  <= $signed(cfg_data[15:0]);
        REG_SIDE_HALF_WIDTH: zcfg_r.side_half_width <= cfg_data[15:0];
        REG_MARGIN_DISTANCE: zcfg_r.margin_distance <= cfg_data[15:0];
        REG_BODY_RADIUS:     zcfg_r.body_radius     <= cfg_data[15:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  // Beam angle steps on every sample, valid or not, and reloads after the
  // scan end; a new angle_start only shows at that reload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= ANGLE_BITS'(ANGLE_START_RST);
    end else if (in_acc) begin
      if (in_data.scan_end) begin
        beam_angle_r <= ANGLE_BITS'(angle_start_r);
      end else begin
        beam_angle_r <= beam_angle_r + ANGLE_BITS'(angle_step_r);
      end
    end
  end

  // scale to a 32-bit binary angle for the rotator
  assign bin_angle = ZW'(beam_angle_r) << ASH;

  assign ctl.range_ok = in_data.range_ok;
  assign ctl.scan_end = in_data.scan_end;

  lsoz_rotator u_rotator (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && in_data.range_ok),
    .range_mm (in_data.range_mm),
    .bin_angle(bin_angle),
    .vld_out  (rot_vld),
    .vec_out  (rot_vec)
  );

  lsoz_zone u_zone (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .ctl      (ctl),
    .cfg      (zcfg_r),
    .rot_vld  (rot_vld),
    .rot      (rot_vec),
    .busy     (busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the laser scan obstacle zone block.
`timescale 1ns / 1ps

module tb;
  import lsoz_pkg::*;

  // Cycles allowed for a sample to finish once its handshake is done, leaving
  // room before touching the registers.
  localparam int DRAIN_CYCLES   = 40;
  // Cycles without any beat before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCAN_PHASES    = 10;
  localparam int PHASE_SAMPLES  = 80;

  // Register indexes past the map; writes there must be dropped.
  localparam logic [CFG_AW-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;
  localparam longint GAIN = 64'sd652032874;

  // atan(2^-i) in 2^-32 turn
  localparam longint BEAM_ARCS [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_AW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;

  laser_scan_obstacle_zones DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers, beam angle and the four sticky flags.
  // Registers start at the documented reset values.
  // ---------------------------------------------------------------------------
  logic [22:0]        step_q     = ANGLE_STEP_RST;
  logic [23:0]        start_q    = ANGLE_START_RST;
  logic signed [15:0] xshift_q   = SENSOR_X_SHIFT_RST;
  logic [15:0]        side_q     = SIDE_HALF_WIDTH_RST;
  logic [15:0]        margin_q   = MARGIN_DISTANCE_RST;
  logic [15:0]        body_q     = BODY_RADIUS_RST;
  logic [23:0]        beam_q     = ANGLE_START_RST;
  out_item_t          seen_q     = '0;

  in_item_t  pending_samples [$];   // fed by the stimulus, drained by the driver
  out_item_t zone_flags_due [$];    // flag sets still owed by the block

  int  n_pushed, n_taken, n_invalid, n_scans, n_cfg, n_fail;
  int  n_results, n_left, n_front, n_right, n_approach;
  bit  calm = 1'b1;                 // no idling on either side while set

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Iterative rotation of (r, 0) by the beam angle, Q.4 result with the
  // CORDIC gain already taken out. Angles in the back half start from -r.
  task automatic rotate_beam(input logic [15:0] r, input logic [23:0] ang,
                             output longint px, output longint py);
    logic [31:0] t;
    logic [31:0] q;
    longint x, y, z, dx, dy;
    t = {ang, 8'h00};
    x = longint'(r) * 16;
    y = 0;
    q = t + QUARTER;
    if (q[31]) begin
      x = -x;
      t = t + HALF;
    end
    z = longint'($signed(t));
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - BEAM_ARCS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + BEAM_ARCS[i];
      end
    end
    px = (x * GAIN) >>> 30;
    py = (y * GAIN) >>> 30;
  endtask

  // Folds one accepted sample into the sticky flags; a scan end queues the
  // flag set it closes and reloads the beam angle.
  task automatic fold_sample(input in_item_t s);
    longint px, py, d2, base, side4, t_half, t_one, t_two;
    if (s.range_ok) begin
      rotate_beam(s.range_mm, beam_q, px, py);
      px = px + longint'(xshift_q) * 16;
      d2 = px * px + py * py;
      base = longint'(body_q) * 16;
      if (d2 >= base * base) begin
        side4  = longint'(side_q) * 16;
        t_half = base + longint'(margin_q) * 8;
        t_one  = base + longint'(margin_q) * 16;
        t_two  = base + longint'(margin_q) * 32;
        if (py > side4) begin
          if (d2 < t_half * t_half) seen_q.near_left = 1'b1;
        end else if (py < -side4) begin
          if (d2 < t_half * t_half) seen_q.near_right = 1'b1;
        end else begin
          if (d2 < t_one * t_one) seen_q.near_front = 1'b1;
          if (d2 < t_two * t_two) seen_q.approaching_front = 1'b1;
        end
      end
    end else begin
      n_invalid++;
    end
    beam_q = beam_q + 24'(step_q);
    if (s.scan_end) begin
      zone_flags_due = {zone_flags_due, seen_q};
      seen_q = '0;
      beam_q = start_q;
      n_scans++;
    end
  endtask

  function automatic void store_reg(input logic [CFG_AW-1:0] idx,
                                    input logic [CFG_DW-1:0] val);
    case (idx)
      REG_ANGLE_STEP:      step_q   = val[22:0];
      REG_ANGLE_START:     start_q  = val;       // used at the next reload only
      REG_SENSOR_X_SHIFT:  xshift_q = val[15:0];
      REG_SIDE_HALF_WIDTH: side_q   = val[15:0];
      REG_MARGIN_DISTANCE: margin_q = val[15:0];
      REG_BODY_RADIUS:     body_q   = val[15:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one beat per queued sample, random gap after each beat.
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_sample(in_data);
        n_taken++;
      end
      // slot is free when nothing is offered or the offer just went through
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_samples.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_samples.pop_front();
          in_gap   <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and stall generator. After each result beat a stall count
  // is drawn; it runs down only while a result is offered, so stalls land on
  // waiting results as well as on idle stretches.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  task automatic flag_check(input string name, input logic e, input logic a);
    if (e !== a) begin
      $display("%0t ns: %s expected %0b got %0b", $time, name, e, a);
      n_fail++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (zone_flags_due.size() == 0) begin
      $display("%0t ns: unexpected result beat %b", $time, got);
      n_fail++;
    end else begin
      want = zone_flags_due.pop_front();
      flag_check("near_left", want.near_left, got.near_left);
      flag_check("near_front", want.near_front, got.near_front);
      flag_check("near_right", want.near_right, got.near_right);
      flag_check("approaching_front", want.approaching_front, got.approaching_front);
    end
    n_results++;
    n_left     += got.near_left;
    n_front    += got.near_front;
    n_right    += got.near_right;
    n_approach += got.approaching_front;
  endtask

  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_result(out_data);
      n = draw_wait();
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any beat on any channel restarts the count.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d flag sets outstanding",
               $time, quiet_cycles, zone_flags_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_reg(idx, val);
    n_cfg++;
  endtask

  // Random junk above the register width; the block must mask it off.
  function automatic logic [CFG_DW-1:0] with_junk(input int unsigned v, input int w);
    logic [CFG_DW-1:0] junk;
    junk = CFG_DW'($urandom);
    return (junk << w) | CFG_DW'(v);
  endfunction

  task automatic write_all(input int unsigned stp, input int unsigned strt,
                           input int unsigned xs, input int unsigned sd,
                           input int unsigned mg, input int unsigned bd);
    write_reg(REG_ANGLE_STEP, with_junk(stp, 23));
    write_reg(REG_ANGLE_START, CFG_DW'(strt));
    write_reg(REG_SENSOR_X_SHIFT, with_junk(xs, 16));
    write_reg(REG_SIDE_HALF_WIDTH, with_junk(sd, 16));
    write_reg(REG_MARGIN_DISTANCE, with_junk(mg, 16));
    write_reg(REG_BODY_RADIUS, with_junk(bd, 16));
  endtask

  task automatic push_sample(input int unsigned r, input bit ok, input bit last);
    in_item_t s;
    s.range_mm = r[15:0];
    s.range_ok = ok;
    s.scan_end = last;
    pending_samples = {pending_samples, s};
    n_pushed++;
  endtask

  // Wait for every sample and every owed result, then let the pipe drain.
  task automatic settle();
    do @(negedge clk); while (n_taken != n_pushed || zone_flags_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly ranges around the zone thresholds of the current setting.
  function automatic int unsigned pick_range();
    int unsigned lo, hi;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 1) ? 65535 : $urandom_range(0, 3);
      default: begin
        lo = (body_q > 200) ? body_q - 200 : 0;
        hi = body_q + 2 * margin_q + 300;
        if (hi > 65535) hi = 65535;
        return $urandom_range(lo, hi);
      end
    endcase
  endfunction

  // Random scans; a few end early or carry invalid samples, and the phase may
  // stop in the middle of a scan so that later writes meet a half-done scan.
  task automatic push_scans(input int budget);
    int len;
    bit closed;
    closed = ($urandom_range(0, 3) != 0);
    while (budget > 0) begin
      len = $urandom_range(1, 40);
      if (len > budget) len = budget;
      for (int i = 0; i < len; i++) begin
        push_sample(pick_range(), $urandom_range(0, 9) != 0,
                    (i == len - 1 && (len < budget || closed)) ||
                    $urandom_range(0, 49) == 0);
      end
      budget -= len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values (zero step: all beams at the
    // start angle, pointing back and to the right).
    @(negedge clk);
    push_sample(0, 1'b1, 1'b0);        // only the sensor offset: front, close
    push_sample(65535, 1'b1, 1'b0);    // longest range
    push_sample(300, 1'b0, 1'b0);      // invalid sample
    push_sample(300, 1'b0, 1'b1);      // invalid sample closing the scan
    push_sample(0, 1'b0, 1'b1);        // scan of invalid samples only
    push_sample(100, 1'b1, 1'b1);      // inside the casing: dropped
    settle();

    // Quarter turn steps walk the beam through all four quadrants and wrap.
    write_reg(REG_ANGLE_STEP, 24'h40_0000);
    write_reg(REG_UNMAPPED_LO, CFG_DW'($urandom));
    write_reg(REG_UNMAPPED_HI, CFG_DW'($urandom));
    @(negedge clk);
    push_sample(60, 1'b1, 1'b1);       // reload the angle first
    push_sample(150, 1'b1, 1'b0);
    push_sample(250, 1'b1, 1'b0);
    push_sample(200, 1'b1, 1'b0);
    push_sample(400, 1'b1, 1'b0);
    push_sample(65535, 1'b1, 1'b0);
    push_sample(170, 1'b0, 1'b0);
    push_sample(1, 1'b1, 1'b1);
    settle();

    // Zero geometry: every point survives, no threshold can be undercut.
    write_all(24'h20_0000, 24'h00_0000, 0, 0, 0, 0);
    @(negedge clk);
    push_sample(0, 1'b1, 1'b0);
    push_sample(120, 1'b1, 1'b0);
    push_sample(65535, 1'b1, 1'b0);
    push_sample(5, 1'b1, 1'b1);
    settle();

    // Random part: the first two settings sit on the register extremes.
    for (int p = 0; p < SCAN_PHASES; p++) begin
      calm = (p % 4 == 3);
      if (p == 0) begin
        write_all(23'h7F_FFFF, 24'h80_0000, 16'h8000, 0, 0, 0);
      end else if (p == 1) begin
        write_all(0, 24'h7F_FFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else if (p % 3 == 2) begin
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        write_all($urandom_range(100000, 2000000), $urandom,
                  $urandom_range(0, 400) - 200, $urandom_range(0, 300),
                  $urandom_range(0, 400), $urandom_range(0, 300));
      end
      if ($urandom_range(0, 1)) write_reg(REG_UNMAPPED_HI, CFG_DW'($urandom));
      @(negedge clk);
      push_scans(PHASE_SAMPLES);
      settle();
    end

    if (zone_flags_due.size() != 0) begin
      $display("%0t ns: %0d flag sets never arrived", $time, zone_flags_due.size());
      n_fail++;
    end

    $display("Covered %0d samples (%0d invalid) in %0d scans, %0d register writes.",
             n_taken, n_invalid, n_scans, n_cfg);
    $display("Checked %0d flag sets; left %0d, front %0d, right %0d, approaching %0d.",
             n_results, n_left, n_front, n_right, n_approach);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lsoz_pkg.sv
rtl/lsoz_cell.sv
rtl/lsoz_rotator.sv
rtl/lsoz_zone.sv
rtl/laser_scan_obstacle_zones.sv
dv/tb.sv
